// ===== rtl/merge_sort_engine_unit_assert.svh =====
// assertion macros used by the checker file of the merge sort engine
// needs nothing but a clock and an active-low reset in the calling scope
`ifndef MERGE_SORT_ENGINE_UNIT_ASSERT_SVH
`define MERGE_SORT_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define MSORT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSORT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/msort_pkg.sv =====
// shared types and constants of the merge sort engine
// used by every rtl module of the block; depends on nothing
package msort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int PTR_W     = ADDR_W + 2;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [PTR_W-1:0]  t_ptr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_CHK,
        S_BLK,
        S_MERGE,
        S_NEXT,
        S_EMIT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic blk_init;
        logic merge;
        logic next_blk;
        logic emit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic blk_end;
        logic run_end;
        logic sort_end;
        logic emit_end;
    } t_sts;

endpackage

// ===== rtl/merge_sort_engine_unit.sv =====
// top level of the merge sort engine: controller and datapath
// depends on msort_pkg, msort_ctrl, msort_dp (and msort_ram below it)
//
// Usage:
//   An item (i_value, i_last) is taken at a rising edge with start high and busy
//   low. Items with i_last low are stored and busy stays low, so a run loads at
//   one item per cycle. Up to 64 values are kept per run; further values are
//   dropped and o_overflow is set on every result of that run. An item with
//   i_last high ends the run: busy rises and the stored values are sorted
//   ascending (signed) by bottom-up merge passes between two buffers, with
//   ceil(log2 n) passes for n stored values.
//   The sorted values then leave one per cycle, each marked by o_valid for a
//   single cycle, the final one with o_last_out. The receiver cannot stall:
//   results must be taken as they appear. busy drops in the cycle after the
//   final result and the next run may start. Reset (i_rst_n low, synchronous)
//   empties the store, clears the overflow flag and returns the block to idle.
module merge_sort_engine_unit import msort_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_data i_value,
    input  logic  i_last,
    output logic  o_valid,
    output t_data o_sorted_value,
    output logic  o_last_out,
    output logic  o_overflow
);

    t_cmd cmd;
    t_sts sts;
    logic ctrl_busy;

    msort_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    msort_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    assign busy = ctrl_busy;

endmodule

// ===== rtl/msort_ram.sv =====
// generic buffer of the merge sort engine: one write port, two registered read ports
// depends on msort_pkg
module msort_ram import msort_pkg::*; (
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_data i_wdata,
    input  t_addr i_raddr_a,
    input  t_addr i_raddr_b,
    output t_data o_rdata_a,
    output t_data o_rdata_b
);

    t_data r_mem [MAX_ITEMS];
    t_data r_rdata_a;
    t_data r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/msort_ctrl.sv =====
// controller of the merge sort engine: load, merge passes and emission sequencing
// depends on msort_pkg; drives the datapath through t_cmd, watches t_sts
module msort_ctrl import msort_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_last,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT:  n_state = S_CHK;
            S_CHK: begin
                n_state = i_sts.sort_end ? S_EMIT : S_BLK;
            end
            S_BLK:   n_state = S_MERGE;
            S_MERGE: begin
                if (i_sts.blk_end) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_state = i_sts.run_end ? S_CHK : S_BLK;
            end
            S_EMIT: begin
                if (i_sts.emit_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:  o_cmd.load      = i_start;
            S_INIT:  o_cmd.sort_init = 1'b1;
            S_CHK:   o_cmd           = '0;
            S_BLK:   o_cmd.blk_init  = 1'b1;
            S_MERGE: o_cmd.merge     = 1'b1;
            S_NEXT:  o_cmd.next_blk  = 1'b1;
            S_EMIT:  o_cmd.emit      = 1'b1;
            S_FLUSH: o_cmd.clear     = 1'b1;
            default: o_cmd           = '0;
        endcase
    end

endmodule

// ===== rtl/msort_dp.sv =====
// datapath of the merge sort engine: two ping-pong buffers, merge pointers, output register
// depends on msort_pkg and msort_ram; commanded by msort_ctrl
module msort_dp import msort_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_data i_value,
    output t_sts  o_sts,
    output logic  o_valid,
    output t_data o_sorted_value,
    output logic  o_last_out,
    output logic  o_overflow
);

    t_cnt  r_count;
    logic  r_drop;
    logic  r_src;
    logic  r_ovld;
    logic  r_olast;
    logic  r_oovf;
    t_ptr  r_w;
    t_ptr  r_lo;
    t_ptr  r_mid;
    t_ptr  r_hi;
    t_ptr  r_a;
    t_ptr  r_b;
    t_ptr  r_k;
    t_addr r_e;

    t_ptr  n_ext;
    t_ptr  sum_mid;
    t_ptr  sum_hi;
    t_ptr  mid_c;
    t_ptr  hi_c;
    t_ptr  a_inc;
    t_ptr  b_inc;
    logic  take_a;
    t_data head_a;
    t_data head_b;
    t_data q0_a;
    t_data q0_b;
    t_data q1_a;
    t_data q1_b;
    t_addr raddr_a;
    t_addr raddr_b;
    logic  we0;
    logic  we1;
    t_addr waddr0;
    t_data wdata0;
    t_data merge_data;

    // sorting buffers
    msort_ram u_buf0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr0),
        .i_wdata   (wdata0),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (q0_a),
        .o_rdata_b (q0_b)
    );

    msort_ram u_buf1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (r_k[ADDR_W-1:0]),
        .i_wdata   (merge_data),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (q1_a),
        .o_rdata_b (q1_b)
    );

    assign head_a = r_src ? q1_a : q0_a;
    assign head_b = r_src ? q1_b : q0_b;

    assign n_ext   = PTR_W'(r_count);
    assign sum_mid = PTR_W'(r_lo + r_w);
    assign sum_hi  = PTR_W'(r_lo + PTR_W'(r_w << 1));
    assign mid_c   = (sum_mid > n_ext) ? n_ext : sum_mid;
    assign hi_c    = (sum_hi > n_ext) ? n_ext : sum_hi;
    assign a_inc   = PTR_W'(r_a + PTR_W'(1));
    assign b_inc   = PTR_W'(r_b + PTR_W'(1));

    assign take_a     = (r_a < r_mid) &&
                        (!(r_b < r_hi) || ($signed(head_a) < $signed(head_b)));
    assign merge_data = take_a ? head_a : head_b;

    always_comb begin
        raddr_a = r_e;
        raddr_b = r_e;
        priority if (i_cmd.blk_init) begin
            raddr_a = r_lo[ADDR_W-1:0];
            raddr_b = mid_c[ADDR_W-1:0];
        end else if (i_cmd.merge) begin
            raddr_a = take_a ? a_inc[ADDR_W-1:0] : r_a[ADDR_W-1:0];
            raddr_b = take_a ? r_b[ADDR_W-1:0] : b_inc[ADDR_W-1:0];
        end else begin
            raddr_a = r_e;
            raddr_b = r_e;
        end
    end

    // buffer 0 takes loads and even passes, buffer 1 odd passes (the first pass writes buffer 1)
    assign we0    = (i_cmd.load && (r_count < CNT_W'(MAX_ITEMS))) || (i_cmd.merge && r_src);
    assign we1    = i_cmd.merge && !r_src;
    assign waddr0 = i_cmd.load ? r_count[ADDR_W-1:0] : r_k[ADDR_W-1:0];
    assign wdata0 = i_cmd.load ? i_value : merge_data;

    assign o_sts.blk_end  = (PTR_W'(r_k + PTR_W'(1)) == r_hi);
    assign o_sts.run_end  = (r_lo >= n_ext);
    assign o_sts.sort_end = (r_w >= n_ext);
    assign o_sts.emit_end = (CNT_W'(r_e) == CNT_W'(r_count - CNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_src   <= 1'b0;
            r_ovld  <= 1'b0;
            r_olast <= 1'b0;
        end else begin
            r_ovld  <= i_cmd.emit;
            r_olast <= i_cmd.emit && o_sts.emit_end;
            if (i_cmd.load) begin
                if (r_count < CNT_W'(MAX_ITEMS)) begin
                    r_count <= CNT_W'(r_count + CNT_W'(1));
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.sort_init) begin
                r_src <= 1'b0;
            end
            if (i_cmd.next_blk && o_sts.run_end) begin
                r_src <= !r_src;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_oovf <= r_drop;
        if (i_cmd.sort_init) begin
            r_w  <= PTR_W'(1);
            r_lo <= '0;
            r_e  <= '0;
        end
        if (i_cmd.blk_init) begin
            r_a   <= r_lo;
            r_b   <= mid_c;
            r_k   <= r_lo;
            r_mid <= mid_c;
            r_hi  <= hi_c;
        end
        if (i_cmd.merge) begin
            if (take_a) begin
                r_a <= a_inc;
            end else begin
                r_b <= b_inc;
            end
            r_k <= PTR_W'(r_k + PTR_W'(1));
            if (o_sts.blk_end) begin
                r_lo <= sum_hi;
            end
        end
        if (i_cmd.next_blk && o_sts.run_end) begin
            r_w  <= PTR_W'(r_w << 1);
            r_lo <= '0;
        end
        if (i_cmd.emit) begin
            r_e <= ADDR_W'(r_e + ADDR_W'(1));
        end
    end

    assign o_valid        = r_ovld;
    assign o_sorted_value = head_a;
    assign o_last_out     = r_olast;
    assign o_overflow     = r_oovf;

endmodule

// ===== rtl/msort_chk.sv =====
// port-level checker of the merge sort engine, bound to the top level
// depends on msort_pkg and merge_sort_engine_unit_assert.svh
`include "merge_sort_engine_unit_assert.svh"

module msort_chk import msort_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  start,
    input logic  busy,
    input logic  i_last,
    input logic  o_valid,
    input t_data o_sorted_value,
    input logic  o_last_out
);

    `MSORT_ASSERT_NOW(a_valid_busy, i_clk, i_rst_n, o_valid, busy, "result outside a busy phase")
    `MSORT_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && o_last_out, !o_valid, "result after final item")
    `MSORT_ASSERT_NEXT(a_run_busy, i_clk, i_rst_n, start && !busy && i_last, busy, "final item did not start sort")
    `MSORT_ASSERT_NEXT(a_gapless, i_clk, i_rst_n, o_valid && !o_last_out, o_valid, "gap inside sorted run")
    `MSORT_ASSERT_NEXT(a_ascending, i_clk, i_rst_n, o_valid && !o_last_out, $signed(o_sorted_value) >= $signed($past(o_sorted_value)), "sorted run not ascending")

endmodule

bind merge_sort_engine_unit msort_chk u_msort_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last         (i_last),
    .o_valid        (o_valid),
    .o_sorted_value (o_sorted_value),
    .o_last_out     (o_last_out)
);
